>>> rtl/sdp_pkg.sv
// Shared types, character codes and line phase codes for the event stream
// data line parser. No dependencies; every other file uses this package.
package sdp_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam int unsigned PREFIX_LEN  = 5;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 8;

  // Line phase codes. Codes 1 to 4 count matched prefix characters.
  localparam logic [2:0] PH_START        = 3'd0;
  localparam logic [2:0] PH_AFTER_PREFIX = 3'd5;
  localparam logic [2:0] PH_PAYLOAD      = 3'd6;
  localparam logic [2:0] PH_IGNORE       = 3'd7;

  typedef struct packed {
    logic [2:0] phase;
    logic       cr_held;
    logic       payload_begun;
    logic       event_has_data;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       event_end;
    logic       last;
  } result_t;

  // Expected character of the "data:" prefix at a given position.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h64;  // d
      3'd1:    c = 8'h61;  // a
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h3A;  // colon
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/sse_data_field_parser.sv
// Top level of the event stream data line parser; instantiates sdp_decode
// and sdp_out_queue and uses sdp_pkg.
//
// The parser takes one stream word per cycle and splits the stream into
// lines at LF, emitting the payload words of "data:" lines (one leading
// space skipped), a newline separator before each payload after the first
// of an event, and an end marker (event_end high, out_byte zero) when a
// blank line closes an event that holds data. A CR right before LF is
// dropped; any other CR becomes content ahead of the word that follows it.
// An accepted word is held in an input register and decoded combinationally
// against the line state, and its zero to three results land in a result
// queue of QUEUE_DEPTH entries whose head drives the output channel, so each
// result passes both the input register and the queue. The input side takes
// a word every cycle as long as the queue has room for three more results,
// so the sustained rate is one word per cycle while each word yields at most
// one result; the output port delivers one result per cycle while out_ready
// is high, which sets the rate when words yield more. last_of_run marks the
// final result caused by a word; words that cause nothing produce no output.
// QUEUE_DEPTH must be a power of two of at least four.
module sse_data_field_parser #(
  parameter int unsigned QUEUE_DEPTH = sdp_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       event_end,
  output logic       last_of_run
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Line state.
  sdp_pkg::state_t st;
  sdp_pkg::state_t st_next;

  sdp_pkg::result_t [sdp_pkg::MAX_RESULTS-1:0] dec_res;
  logic [sdp_pkg::CNT_W-1:0]                   dec_count;
  logic [sdp_pkg::CNT_W-1:0]                   wr_count;
  logic                                        q_room;
  logic                                        advance;
  sdp_pkg::result_t                            head;

  // The held word is decoded and committed once the queue can take its
  // worst case of three results.
  assign advance  = s1_valid && q_room;
  assign in_ready = !s1_valid || advance;
  assign wr_count = advance ? dec_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  sdp_decode u_decode (
    .cur   (st),
    .data  (s1_byte),
    .nxt   (st_next),
    .res   (dec_res),
    .count (dec_count)
  );

  sdp_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_data  (dec_res),
    .room     (q_room),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign out_byte    = head.data;
  assign event_end   = head.event_end;
  assign last_of_run = head.last;

  // The end marker is always the only, and so the last, result of its word.
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_end |-> last_of_run && out_byte == 8'h00)
    else $error("end marker malformed");

  // The separator decision is only ever made inside a payload.
  a_begun_in_payload: assert property (@(posedge clk) disable iff (rst)
    st.payload_begun |-> st.phase == sdp_pkg::PH_PAYLOAD)
    else $error("payload_begun outside payload phase");

  // A held word that cannot be committed stays in the input register.
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !q_room |=> s1_valid && $stable(s1_byte) && $stable(st))
    else $error("held word lost while queue full");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("results visible after reset");

endmodule

>>> rtl/sdp_decode.sv
// Combinational decode of one stream word against the line state.
// Produces the next state and up to three results; uses sdp_pkg.
module sdp_decode (
  input  sdp_pkg::state_t                                cur,
  input  logic [7:0]                                     data,
  output sdp_pkg::state_t                                nxt,
  output sdp_pkg::result_t [sdp_pkg::MAX_RESULTS-1:0]    res,
  output logic [sdp_pkg::CNT_W-1:0]                      count
);

  typedef struct packed {
    sdp_pkg::state_t st;
    logic            sep;
    logic            emit;
  } step_t;

  // One content character applied to the line state.
  function automatic step_t content_step(input sdp_pkg::state_t s, input logic [7:0] c);
    step_t r;
    logic  pay;
    r.st   = s;
    r.sep  = 1'b0;
    r.emit = 1'b0;
    pay    = 1'b0;
    if (s.phase < 3'(sdp_pkg::PREFIX_LEN)) begin
      if (c == sdp_pkg::prefix_char(s.phase)) r.st.phase = s.phase + 3'd1;
      else r.st.phase = sdp_pkg::PH_IGNORE;
    end else if (s.phase == sdp_pkg::PH_AFTER_PREFIX) begin
      r.st.phase = sdp_pkg::PH_PAYLOAD;
      pay = (c != sdp_pkg::CH_SP);
    end else if (s.phase == sdp_pkg::PH_PAYLOAD) begin
      pay = 1'b1;
    end
    if (pay) begin
      if (!s.payload_begun) begin
        r.st.payload_begun = 1'b1;
        r.sep = s.event_has_data;
      end
      r.emit = 1'b1;
      r.st.event_has_data = 1'b1;
    end
    return r;
  endfunction

  step_t                                      st_cr;
  step_t                                      st_b;
  sdp_pkg::state_t                            mid;
  sdp_pkg::result_t [sdp_pkg::MAX_RESULTS-1:0] r;
  logic [sdp_pkg::CNT_W-1:0]                  n;

  always_comb begin
    nxt   = cur;
    r     = '0;
    n     = '0;
    st_cr = '0;
    st_b  = '0;
    mid   = cur;
    if (data == sdp_pkg::CH_LF) begin
      nxt.cr_held = 1'b0;
      if (cur.phase == sdp_pkg::PH_START) begin
        if (cur.event_has_data) begin
          r[n].data      = 8'h00;
          r[n].event_end = 1'b1;
          n = n + 1'b1;
          nxt.event_has_data = 1'b0;
        end
      end else if (cur.phase == sdp_pkg::PH_AFTER_PREFIX ||
                   cur.phase == sdp_pkg::PH_PAYLOAD) begin
        if (!cur.payload_begun && cur.event_has_data) begin
          r[n].data = sdp_pkg::CH_LF;
          n = n + 1'b1;
        end
      end
      nxt.phase         = sdp_pkg::PH_START;
      nxt.payload_begun = 1'b0;
    end else begin
      // A held CR that is not followed by LF is ordinary content first.
      if (cur.cr_held) begin
        st_cr = content_step(cur, sdp_pkg::CH_CR);
        mid   = st_cr.st;
        mid.cr_held = 1'b0;
        if (st_cr.sep) begin
          r[n].data = sdp_pkg::CH_LF;
          n = n + 1'b1;
        end
        if (st_cr.emit) begin
          r[n].data = sdp_pkg::CH_CR;
          n = n + 1'b1;
        end
      end
      nxt = mid;
      if (data == sdp_pkg::CH_CR) begin
        nxt.cr_held = 1'b1;
      end else begin
        st_b = content_step(mid, data);
        nxt  = st_b.st;
        if (st_b.sep) begin
          r[n].data = sdp_pkg::CH_LF;
          n = n + 1'b1;
        end
        if (st_b.emit) begin
          r[n].data = data;
          n = n + 1'b1;
        end
      end
    end
    for (int i = 0; i < sdp_pkg::MAX_RESULTS; i++) begin
      r[i].last = (n == sdp_pkg::CNT_W'(i + 1));
    end
  end

  assign res   = r;
  assign count = n;

endmodule

>>> rtl/sdp_out_queue.sv
// Result queue: takes up to three results a cycle, hands out one a cycle
// if rd_ready is high; the head drives the output directly; uses sdp_pkg.
module sdp_out_queue #(
  parameter int unsigned DEPTH = sdp_pkg::QUEUE_DEPTH
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [sdp_pkg::CNT_W-1:0]                   wr_count,
  input  sdp_pkg::result_t [sdp_pkg::MAX_RESULTS-1:0] wr_data,
  output logic                                        room,
  output logic                                        rd_valid,
  input  logic                                        rd_ready,
  output sdp_pkg::result_t                            rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sdp_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_next;
  logic             rd_fire;

  assign rd_valid  = (fill != '0);
  assign rd_fire   = rd_valid && rd_ready;
  assign rd_data   = mem[rd_ptr];
  assign room      = (fill <= CW'(DEPTH - sdp_pkg::MAX_RESULTS));
  assign fill_next = fill + CW'(wr_count) - CW'(rd_fire);

  always_ff @(posedge clk) begin
    for (int i = 0; i < sdp_pkg::MAX_RESULTS; i++) begin
      if (sdp_pkg::CNT_W'(i) < wr_count) mem[wr_ptr + AW'(i)] <= wr_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(wr_count);
      if (rd_fire) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill_next;
    end
  end

endmodule
